// ===== design/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the frame deframer: the input and result
// words, the command word between the parser and the output stage.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;
  localparam logic [3:0] OP_CLOSE    = 4'h8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } in_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       message_end;
    logic       connection_open;
    logic       chunk_end;
  } out_t;

  // One classified byte, ready for unmasking.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       is_payload;
    logic       last;
    logic [3:0] opcode;
    logic       link;
    logic       chunk;
  } cmd_t;

endpackage

// ===== design/wsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front
// Header parser. Tracks the frame header fields byte by byte and tags each
// accepted byte with its key byte, opcode and end-of-frame mark.
// ----------------------------------------------------------------------------
module wsd_front #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wsd_pkg::in_t  in_data,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output wsd_pkg::cmd_t cmd
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4
  } phase_t;

  phase_t                 phase, phase_next;
  logic [3:0]             header_count, header_count_next;
  logic [3:0]             opcode, opcode_next;
  logic                   mask_en, mask_en_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_index, mask_index_next;
  logic                   link_open, link_open_next;

  logic       accept;
  logic       after_len;
  logic       start_pay;
  logic       finish;
  logic [7:0] b;
  logic [6:0] len7;
  logic [7:0] key_byte;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;
  assign b         = in_data.data_byte;
  assign len7      = b[6:0];

  always_comb begin
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    opcode_next       = opcode;
    mask_en_next      = mask_en;
    remaining_next    = remaining;
    mask_key_next     = mask_key;
    mask_index_next   = mask_index;
    link_open_next    = link_open;
    after_len         = 1'b0;
    start_pay         = 1'b0;
    finish            = 1'b0;
    cmd.is_payload    = 1'b0;
    cmd.key           = 8'h00;

    unique case (phase)
      PH_HDR1: begin
        mask_en_next = b[7];
        if (len7 < LEN7_EXT16) begin
          remaining_next = {{(LENGTH_BITS-7){1'b0}}, len7};
          after_len      = 1'b1;
        end else begin
          header_count_next = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          remaining_next    = '0;
          phase_next        = PH_EXT;
        end
      end
      PH_EXT: begin
        remaining_next    = {remaining[LENGTH_BITS-9:0], b};
        header_count_next = header_count - 4'd1;
        after_len         = (header_count_next == 4'd0);
      end
      PH_KEY: begin
        mask_key_next     = {mask_key[23:0], b};
        header_count_next = header_count + 4'd1;
        start_pay         = (header_count_next >= KEY_BYTES);
      end
      PH_PAY: begin
        cmd.is_payload  = 1'b1;
        cmd.key         = mask_en ? key_byte : 8'h00;
        mask_index_next = mask_index + 2'd1;
        remaining_next  = remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        finish          = (remaining_next == '0);
      end
      default: begin
        // Unused phase codes behave like the first header byte.
        opcode_next       = b[3:0];
        mask_en_next      = 1'b0;
        header_count_next = 4'd0;
        phase_next        = PH_HDR1;
      end
    endcase

    if (after_len) begin
      if (mask_en_next) begin
        phase_next        = PH_KEY;
        header_count_next = 4'd0;
        mask_key_next     = 32'h0;
      end else begin
        start_pay = 1'b1;
      end
    end

    if (start_pay) begin
      mask_index_next = 2'd0;
      if (remaining_next == '0) begin
        finish = 1'b1;
      end else begin
        phase_next = PH_PAY;
      end
    end

    if (finish) begin
      if (opcode_next == OP_CLOSE) begin
        link_open_next = 1'b0;
      end
      phase_next        = PH_HDR0;
      header_count_next = 4'd0;
    end

    cmd.data   = b;
    cmd.last   = finish;
    cmd.opcode = opcode_next;
    cmd.link   = link_open_next;
    cmd.chunk  = in_data.chunk_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      header_count <= 4'd0;
      opcode       <= 4'd0;
      mask_en      <= 1'b0;
      remaining    <= '0;
      mask_key     <= 32'h0;
      mask_index   <= 2'd0;
      link_open    <= 1'b1;
    end else if (accept) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      opcode       <= opcode_next;
      mask_en      <= mask_en_next;
      remaining    <= remaining_next;
      mask_key     <= mask_key_next;
      mask_index   <= mask_index_next;
      link_open    <= link_open_next;
    end
  end

endmodule

// ===== design/wsd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_queue
// Small register FIFO of command words between the parser and the output
// stage, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module wsd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wsd_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output wsd_pkg::cmd_t out_cmd
);
  import wsd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign in_ready  = (count != FULL_CNT);
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/wsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back
// Output stage. Unmasks payload bytes and holds the result word in a
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  wsd_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output wsd_pkg::out_t out_data
);
  import wsd_pkg::*;

  out_t result;

  assign cmd_ready = !out_valid || out_ready;

  always_comb begin
    result.payload_valid   = cmd.is_payload;
    result.payload_byte    = cmd.is_payload ? (cmd.data ^ cmd.key) : 8'h00;
    result.frame_opcode    = cmd.opcode;
    result.message_end     = cmd.last;
    result.connection_open = cmd.link;
    result.chunk_end       = cmd.chunk;
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== design/websocket_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side frame deframer: one stream byte in, one result word out.
//
// The input channel (in_valid/in_ready/in_data) takes one received byte per
// word. Every input word yields exactly one result word on the output
// channel (out_valid/out_ready/out_data): an unmasked payload byte with
// payload_valid set, or a header byte with payload_valid clear. Each result
// carries the frame opcode, the end-of-frame mark and the connection flag.
// Throughput is one word per cycle while the receiver takes every result;
// the parser updates its header state once per byte. A byte taken by the
// parser is written into the queue and then loaded into the output
// register, where its result word waits until the receiver takes it.
// When the receiver stalls, the output register holds its word and the
// two-entry queue absorbs further bytes; in_ready drops once it is full.
// Reset clears the parser to expect a new frame header, empties the queue
// and the output register, and marks the connection open. A close frame
// marks it closed until the next reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core #(
  parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wsd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wsd_pkg::out_t out_data
);
  import wsd_pkg::*;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(front_valid),
    .cmd_ready(front_ready),
    .cmd      (front_cmd)
  );

  wsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_cmd   (front_cmd),
    .out_valid(back_valid),
    .out_ready(back_ready),
    .out_cmd  (back_cmd)
  );

  wsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(back_valid),
    .cmd_ready(back_ready),
    .cmd      (back_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== design/wsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input wsd_pkg::out_t out_data
);
  import wsd_pkg::*;

  logic seen_closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_closed <= 1'b0;
    end else if (out_valid && out_ready && !out_data.connection_open) begin
      seen_closed <= 1'b1;
    end
  end

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_zero_header_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'h00)
    else $error("header result carries a nonzero byte");

  // Once a close frame has completed, the link stays closed until reset.
  a_close_sticky: assert property (@(posedge clk) disable iff (rst)
    seen_closed && out_valid |-> !out_data.connection_open)
    else $error("connection reopened after close");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending right after reset");

endmodule

bind websocket_frame_deframer_core wsd_checker u_wsd_checker (.*);
